[sv/bdc_pkg.sv]
// Shared constants, lane control type and width helper for the b-dot detumble controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package bdc_pkg;

	localparam int FIELD_WIDTH_DEF    = 24;
	localparam int GAIN_FRAC_BITS_DEF = 16;
	localparam int GAIN_W             = 32;
	localparam int RATE_W             = 10;
	localparam int PERIOD_W           = 8;
	localparam int CMD_W              = 48;
	localparam int TORQUE_SCALE       = 1000;

	typedef struct packed {
		logic load;
		logic xprod;
		logic scale;
		logic torque;
		logic mul_lo;
		logic mul_hi;
	} lane_ctl_t;

	// derivative, cross product, scale and gain product widths of one lane
	function automatic int acc_width(input int fw);
		int dw;
		int xw;
		begin
			dw = fw + RATE_W + 1;
			xw = dw + fw + 1 + RATE_W;
			acc_width = xw + GAIN_W + 1;
		end
	endfunction

endpackage
`default_nettype wire

[sv/bdc_lane.sv]
// One axis lane: previous sample, derivative, cross term, x1000 scale and split gain product.
// Depends on bdc_pkg.
`default_nettype none
module bdc_lane #(
	parameter int FIELD_WIDTH = bdc_pkg::FIELD_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  bdc_pkg::lane_ctl_t                            ctl,
	input  logic [bdc_pkg::RATE_W-1:0]                    rate,
	input  logic signed [bdc_pkg::GAIN_W:0]               ngain,
	input  logic signed [FIELD_WIDTH-1:0]                 field,
	input  logic signed [FIELD_WIDTH+bdc_pkg::RATE_W:0]   d_a,
	input  logic signed [FIELD_WIDTH+bdc_pkg::RATE_W:0]   d_b,
	input  logic signed [FIELD_WIDTH-1:0]                 b_a,
	input  logic signed [FIELD_WIDTH-1:0]                 b_b,
	output logic signed [FIELD_WIDTH+bdc_pkg::RATE_W:0]   d,
	output logic signed [FIELD_WIDTH-1:0]                 b,
	output logic                                          prev_zero,
	output logic signed [bdc_pkg::acc_width(FIELD_WIDTH)-1:0] acc
);
	import bdc_pkg::*;

	localparam int W  = FIELD_WIDTH;
	localparam int DW = W + RATE_W + 1;
	localparam int PW = DW + W;
	localparam int CW = PW + 1;
	localparam int XW = CW + RATE_W;
	localparam int LW = XW / 2;
	localparam int HW = XW - LW;
	localparam int NW = GAIN_W + 1;
	localparam int RW = acc_width(FIELD_WIDTH);

	logic signed [W-1:0]      prev_q;
	logic signed [W:0]        diff;
	logic signed [DW:0]       d_full;
	logic signed [DW-1:0]     d_q;
	logic signed [W-1:0]      b_q;
	logic signed [PW-1:0]     prod_a_q;
	logic signed [PW-1:0]     prod_b_q;
	logic signed [CW-1:0]     cross_term;
	logic signed [XW-1:0]     x_q;
	logic [LW-1:0]            x_lo;
	logic signed [HW-1:0]     x_hi;
	logic signed [LW+NW:0]    p_lo;
	logic signed [HW+NW-1:0]  p_hi;
	logic signed [RW-1:0]     acc_q;

	assign diff       = $signed({field[W-1], field}) - $signed({prev_q[W-1], prev_q});
	assign d_full     = diff * $signed({1'b0, rate});
	assign cross_term = CW'(prod_a_q) - CW'(prod_b_q);
	assign x_lo       = x_q[LW-1:0];
	assign x_hi       = x_q[XW-1:LW];
	assign p_lo       = $signed({1'b0, x_lo}) * ngain;
	assign p_hi       = x_hi * ngain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctl.load) begin
			prev_q <= field;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q <= d_full[DW-1:0];
			b_q <= field;
		end
		if (ctl.xprod) begin
			prod_a_q <= d_a * b_b;
			prod_b_q <= d_b * b_a;
		end
		if (ctl.scale) begin
			x_q <= ctl.torque ? XW'(cross_term) * XW'(TORQUE_SCALE) : XW'(d_q);
		end
		if (ctl.mul_lo) begin
			acc_q <= RW'(p_lo);
		end else if (ctl.mul_hi) begin
			acc_q <= acc_q + (RW'(p_hi) <<< LW);
		end
	end

	assign d         = d_q;
	assign b         = b_q;
	assign prev_zero = ~|prev_q;
	assign acc       = acc_q;

endmodule
`default_nettype wire

[sv/bdc_merge.sv]
// Merge stage: floors and saturates the three lane products and holds the result request.
// Depends on bdc_pkg.
`default_nettype none
module bdc_merge #(
	parameter int FIELD_WIDTH    = bdc_pkg::FIELD_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = bdc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              load,
	input  logic                                              issued,
	input  logic signed [bdc_pkg::acc_width(FIELD_WIDTH)-1:0] acc_x,
	input  logic signed [bdc_pkg::acc_width(FIELD_WIDTH)-1:0] acc_y,
	input  logic signed [bdc_pkg::acc_width(FIELD_WIDTH)-1:0] acc_z,
	output logic                                              can_load,
	output logic                                              m_tvalid,
	input  logic                                              m_tready,
	output logic [3*bdc_pkg::CMD_W-1:0]                       m_tdata,
	output logic                                              m_tuser
);
	import bdc_pkg::*;

	localparam int RW = acc_width(FIELD_WIDTH);

	function automatic logic [CMD_W-1:0] sat(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] sh;
		logic [RW-CMD_W:0]    hi_bits;
		begin
			sh      = v >>> GAIN_FRAC_BITS;
			hi_bits = sh[RW-1:CMD_W-1];
			if (&hi_bits || ~|hi_bits) begin
				sat = sh[CMD_W-1:0];
			end else if (sh[RW-1]) begin
				sat = {1'b1, {(CMD_W-1){1'b0}}};
			end else begin
				sat = {1'b0, {(CMD_W-1){1'b1}}};
			end
		end
	endfunction

	logic                   valid_q;
	logic [3*CMD_W-1:0]     data_q;
	logic                   issued_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			issued_q <= issued;
			data_q   <= issued ? {sat(acc_z), sat(acc_y), sat(acc_x)} : '0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = issued_q;

endmodule
`default_nettype wire

[sv/bdot_detumble_controller_top.sv]
// Top level of the b-dot detumble controller: configuration registers, sequencer,
// three axis lanes and the merge stage. Depends on bdc_pkg, bdc_lane and bdc_merge.
//
// Usage:
//   s_* carries one magnetometer sample per request (field_x, field_y, field_z).
//   m_* returns one result per sample: cmd_x/y/z in m_tdata, command_issued in m_tuser.
//   cfg_* writes one register per request; cfg_ready is always high. Write only
//   while no sample is in flight.
// A sample that issues no command goes from idle straight to the emit state; a dipole
//   command first walks scale, low and high multiply, a torque command cross product too.
// The sequencer takes no new sample until back in idle; for a command it first walks each
//   lane through cross product (torque mode), scale and a two-pass split gain multiply.
// s_tready is high while the sequencer is idle; a finished result waits in the
//   output register, and the next sample is still taken. If the receiver stalls
//   the sequencer holds its result until the output register frees.
// Reset clears the history (next sample only primes it), sets the decimation
//   count to one, gain to zero, dipole mode, rate 10 Hz and period 10.
`default_nettype none
module bdot_detumble_controller_top #(
	parameter int FIELD_WIDTH    = bdc_pkg::FIELD_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = bdc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// field_x, field_y, field_z, zero pad to whole bytes
	input  logic [((3*FIELD_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// cmd_x, cmd_y, cmd_z
	output logic [3*bdc_pkg::CMD_W-1:0]           m_tdata,
	// command_issued
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [bdc_pkg::GAIN_W-1:0]            cfg_data
);
	import bdc_pkg::*;

	localparam int W  = FIELD_WIDTH;
	localparam int DW = W + RATE_W + 1;
	localparam int RW = acc_width(FIELD_WIDTH);

	localparam logic [1:0] CFG_GAIN   = 2'd0;
	localparam logic [1:0] CFG_TORQUE = 2'd1;
	localparam logic [1:0] CFG_RATE   = 2'd2;
	localparam logic [1:0] CFG_PERIOD = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CROSS,
		ST_SCALE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic                    torque_q;
	logic [RATE_W-1:0]       rate_q;
	logic [PERIOD_W-1:0]     period_q;
	logic [PERIOD_W-1:0]     count_q;
	logic                    issued_q;

	logic                    accept;
	logic                    history;
	logic                    issue;
	logic                    can_load;
	logic                    merge_load;
	logic signed [GAIN_W:0]  ngain;
	lane_ctl_t               ctl;

	logic signed [W-1:0]     field [3];
	logic signed [DW-1:0]    d     [3];
	logic signed [W-1:0]     b     [3];
	logic                    pz    [3];
	logic signed [RW-1:0]    acc   [3];

	assign s_tready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = s_tvalid && s_tready;
	assign history    = !(pz[0] && pz[1] && pz[2]);
	assign issue      = (count_q >= period_q);
	assign ngain      = -$signed({gain_q[GAIN_W-1], gain_q});
	assign merge_load = (state_q == ST_EMIT) && can_load;

	always_comb begin
		ctl        = '0;
		ctl.load   = accept;
		ctl.xprod  = (state_q == ST_CROSS);
		ctl.scale  = (state_q == ST_SCALE);
		ctl.torque = torque_q;
		ctl.mul_lo = (state_q == ST_MUL_LO);
		ctl.mul_hi = (state_q == ST_MUL_HI);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			gain_q   <= '0;
			torque_q <= 1'b0;
			rate_q   <= RATE_W'(10);
			period_q <= PERIOD_W'(10);
			count_q  <= PERIOD_W'(1);
			issued_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN:   gain_q   <= cfg_data;
					CFG_TORQUE: torque_q <= cfg_data[0];
					CFG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
					CFG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
					default:    gain_q   <= gain_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!history) begin
							issued_q <= 1'b0;
							state_q  <= ST_EMIT;
						end else if (!issue) begin
							count_q  <= count_q + PERIOD_W'(1);
							issued_q <= 1'b0;
							state_q  <= ST_EMIT;
						end else begin
							count_q  <= PERIOD_W'(1);
							issued_q <= 1'b1;
							state_q  <= torque_q ? ST_CROSS : ST_SCALE;
						end
					end
				end
				ST_CROSS:  state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign field[i] = s_tdata[i*W +: W];

		bdc_lane #(
			.FIELD_WIDTH(FIELD_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.rate     (rate_q),
			.ngain    (ngain),
			.field    (field[i]),
			.d_a      (d[(i+1)%3]),
			.d_b      (d[(i+2)%3]),
			.b_a      (b[(i+1)%3]),
			.b_b      (b[(i+2)%3]),
			.d        (d[i]),
			.b        (b[i]),
			.prev_zero(pz[i]),
			.acc      (acc[i])
		);
	end

	bdc_merge #(
		.FIELD_WIDTH   (FIELD_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (merge_load),
		.issued  (issued_q),
		.acc_x   (acc[0]),
		.acc_y   (acc[1]),
		.acc_z   (acc[2]),
		.can_load(can_load),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
`default_nettype wire

[tb/bdot_detumble_controller_top_tb.sv]
// Self-checking testbench for the b-dot detumble controller top level.
// Predicts every result, dipole or torque command or none, in a scoreboard class and compares
// each returned result with its prediction. Depends on bdc_pkg and bdot_detumble_controller_top.
module bdot_detumble_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FW = bdc_pkg::FIELD_WIDTH_DEF;
	localparam int CW = bdc_pkg::CMD_W;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_SAMPLES = 178;

	localparam logic [1:0] REG_GAIN        = 2'd0;
	localparam logic [1:0] REG_TORQUE_MODE = 2'd1;
	localparam logic [1:0] REG_SAMPLE_RATE = 2'd2;
	localparam logic [1:0] REG_CMD_PERIOD  = 2'd3;

	localparam logic signed [127:0] CMD_MAX = (128'sd1 <<< (CW - 1)) - 128'sd1;
	localparam logic signed [127:0] CMD_MIN = -(128'sd1 <<< (CW - 1));

	localparam logic [FW-1:0] FIELD_MAX = 24'h7F_FFFF;
	localparam logic [FW-1:0] FIELD_MIN = 24'h80_0000;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          issued;
	} cmd_t;

	class detumble_scoreboard;
		logic signed [31:0] gain;
		logic               torque;
		logic [9:0]         rate;
		logic [7:0]         period;
		logic signed [FW-1:0] prev_x, prev_y, prev_z;
		logic [7:0]         decim_count;
		cmd_t               pending_cmds[$];
		int                 mismatches;

		function new();
			gain = '0;
			torque = 1'b0;
			rate = 10'd10;
			period = 8'd10;
			prev_x = '0;
			prev_y = '0;
			prev_z = '0;
			decim_count = 8'd1;
			mismatches = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [31:0] val);
			case (idx)
				REG_GAIN: gain = val;
				REG_TORQUE_MODE: torque = val[0];
				REG_SAMPLE_RATE: rate = val[9:0];
				REG_CMD_PERIOD: period = val[7:0];
				default: ;
			endcase
		endfunction

		function logic [CW-1:0] clamp_cmd(input logic signed [127:0] v);
			logic signed [127:0] f;
			f = v >>> bdc_pkg::GAIN_FRAC_BITS_DEF;
			if (f > CMD_MAX)
				return CMD_MAX[CW-1:0];
			if (f < CMD_MIN)
				return CMD_MIN[CW-1:0];
			return f[CW-1:0];
		endfunction

		function void note_sample(input logic signed [FW-1:0] bx, by, bz);
			logic signed [127:0] wx, wy, wz, ng, rt, px, py, pz, rx, ry, rz;
			cmd_t c;
			c = '0;
			if (prev_x == 0 && prev_y == 0 && prev_z == 0) begin
				prev_x = bx;
				prev_y = by;
				prev_z = bz;
			end else begin
				wx = bx;
				wy = by;
				wz = bz;
				ng = gain;
				ng = -ng;
				rt = {118'd0, rate};
				px = prev_x;
				py = prev_y;
				pz = prev_z;
				px = (wx - px) * rt * ng;
				py = (wy - py) * rt * ng;
				pz = (wz - pz) * rt * ng;
				prev_x = bx;
				prev_y = by;
				prev_z = bz;
				if (decim_count < period) begin
					decim_count = decim_count + 8'd1;
				end else begin
					decim_count = 8'd1;
					if (torque) begin
						rx = (py * wz - pz * wy) * bdc_pkg::TORQUE_SCALE;
						ry = (pz * wx - px * wz) * bdc_pkg::TORQUE_SCALE;
						rz = (px * wy - py * wx) * bdc_pkg::TORQUE_SCALE;
					end else begin
						rx = px;
						ry = py;
						rz = pz;
					end
					c.x = clamp_cmd(rx);
					c.y = clamp_cmd(ry);
					c.z = clamp_cmd(rz);
					c.issued = 1'b1;
				end
			end
			pending_cmds.push_back(c);
		endfunction

		function void compare_field(input string name, input logic [CW-1:0] e, a);
			if (a !== e) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
					$signed(e), $signed(a));
				mismatches++;
			end
		endfunction

		function void check_result(input logic [3*CW-1:0] data, input logic issued);
			cmd_t e;
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h issued %b",
					$time, data, issued);
				mismatches++;
			end else begin
				e = pending_cmds.pop_front();
				compare_field("cmd_x", e.x, data[CW-1:0]);
				compare_field("cmd_y", e.y, data[2*CW-1:CW]);
				compare_field("cmd_z", e.z, data[3*CW-1:2*CW]);
				compare_field("command_issued", {{(CW-1){1'b0}}, e.issued},
					{{(CW-1){1'b0}}, issued});
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [3*FW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [3*CW-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	detumble_scoreboard sb;
	int src_idle_pct;
	int snk_stall_pct;
	int quiet_cycles;

	bdot_detumble_controller_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("bdot_detumble_controller_top test failed");
			$finish;
		end
	end

	task automatic send_sample(input logic [FW-1:0] fx, fy, fz);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fz, fy, fx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(fx, fy, fz);
	endtask

	task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic write_config(input logic [31:0] gain, input logic mode,
			input logic [9:0] rate, input logic [7:0] period);
		program_reg(REG_GAIN, gain);
		program_reg(REG_TORQUE_MODE, {31'd0, mode});
		program_reg(REG_SAMPLE_RATE, {22'd0, rate});
		program_reg(REG_CMD_PERIOD, {24'd0, period});
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [FW-1:0] pick_field(input logic [FW-1:0] last);
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return FW'($urandom);
		if (sel < 8)
			return last + FW'($urandom_range(2000)) - FW'(1000);
		if (sel == 8) begin
			case ($urandom_range(4))
				0: return FIELD_MAX;
				1: return FIELD_MIN;
				2: return FW'(1);
				3: return {FW{1'b1}};
				default: return FIELD_MIN + FW'(1);
			endcase
		end
		return '0;
	endfunction

	initial begin
		logic [FW-1:0] fx, fy, fz;
		logic [31:0] g;
		logic m;
		logic [9:0] r;
		logic [7:0] per;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_GAIN;
		cfg_data <= '0;
		quiet_cycles <= 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		fx = '0;
		fy = '0;
		fz = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: prime, then one full decimation period
		for (int i = 0; i < 11; i++)
			send_sample(FW'($urandom), FW'($urandom), FW'($urandom));
		drain_results();

		write_config(32'h7FFF_FFFF, 1'b0, 10'd1023, 8'd1);
		send_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX);
		send_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN);
		send_sample(FIELD_MAX, FIELD_MIN, '0);
		send_sample('0, '0, '0);
		send_sample(FW'(1), {FW{1'b1}}, FW'(1));
		send_sample({FW{1'b1}}, FW'(1), '0);
		drain_results();

		write_config(32'h8000_0000, 1'b1, 10'd1023, 8'd1);
		send_sample(FIELD_MAX, FIELD_MIN, FIELD_MAX);
		send_sample(FIELD_MIN, FIELD_MAX, FIELD_MIN);
		send_sample(FIELD_MAX, FIELD_MAX, FIELD_MIN);
		send_sample(FW'(1), FW'(2), FW'(3));
		drain_results();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 48; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 48; end
				default: begin src_idle_pct = 26; snk_stall_pct = 26; end
			endcase
			case (p)
				0: begin g = 32'h0001_0000; m = 1'b0; r = 10'd10; per = 8'd1; end
				1: begin g = $urandom; m = 1'b1; r = 10'($urandom_range(1, 1023)); per = 8'd2; end
				2: begin g = 32'h7FFF_FFFF; m = 1'b1; r = 10'd1023; per = 8'd3; end
				3: begin g = 32'h8000_0000; m = 1'b0; r = 10'd1; per = 8'd255; end
				4: begin g = '0; m = 1'b1; r = 10'd0; per = 8'd0; end
				5: begin g = $urandom; m = 1'b0; r = 10'd1023; per = 8'd0; end
				6: begin
					g = 32'($signed(18'($urandom)));
					m = 1'b1;
					r = 10'($urandom_range(1, 1023));
					per = 8'($urandom_range(1, 4));
				end
				default: begin
					g = $urandom;
					m = 1'($urandom_range(1));
					r = 10'($urandom_range(1, 1023));
					per = 8'd1;
				end
			endcase
			write_config(g, m, r, per);
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				if ($urandom_range(49) == 0) begin
					fx = '0;
					fy = '0;
					fz = '0;
				end else begin
					fx = pick_field(fx);
					fy = pick_field(fy);
					fz = pick_field(fz);
				end
				send_sample(fx, fy, fz);
			end
			drain_results();
		end

		repeat (16) @(posedge clk);
		if (sb.mismatches == 0)
			$display("bdot_detumble_controller_top test passed");
		else
			$display("bdot_detumble_controller_top test failed");
		$finish;
	end
endmodule
